// File: rtl/anp_pkg.sv
`timescale 1ns / 1ps

package anp_pkg;

	localparam int OFFSET_BITS_DEF = 32;

	// descriptor queue between byte scanner and result expander
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam logic [23:0] WIN_START = 24'h000001;
	localparam logic [23:0] WIN_ZERO  = 24'h000000;
	localparam logic [23:0] WIN_EPB   = 24'h000003;
	localparam logic [4:0]  TYPE_SVC_PREFIX = 5'd14;
	localparam logic [4:0]  TYPE_SVC_SLICE  = 5'd20;

	typedef enum logic [1:0] {
		KIND_HEADER  = 2'd0,
		KIND_PAYLOAD = 2'd1,
		KIND_END     = 2'd2
	} kind_t;

	// everything one stream byte causes: optional header record,
	// up to three payload bytes, optional end-of-unit marker
	typedef struct packed {
		logic [7:0]       hdr_byte;
		logic [23:0]      ext;
		logic [31:0]      offset;
		logic             has_hdr;
		logic [1:0]       pay_cnt;
		logic [2:0][7:0]  pay;
		logic             has_end;
	} desc_t;

	typedef struct packed {
		kind_t       kind;
		logic [31:0] nal_offset;
		logic [4:0]  nal_type;
		logic [1:0]  ref_idc;
		logic        forbidden_bit;
		logic [23:0] hdr_ext;
		logic [7:0]  payload_byte;
		logic        last;
	} res_t;

endpackage

// File: rtl/anp_fifo.sv
`timescale 1ns / 1ps

module anp_fifo (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr_en,
	input  anp_pkg::desc_t wr_data,
	output logic           full,
	input  logic           rd_en,
	output anp_pkg::desc_t rd_data,
	output logic           empty
);
	import anp_pkg::*;

	desc_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  count_q;
	logic               do_wr;
	logic               do_rd;

	assign full    = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign empty   = (count_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
		ptr_inc = (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (do_rd) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + QCNT_W'(1);
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - QCNT_W'(1);
			end
		end
	end

endmodule

// File: rtl/anp_front.sv
`timescale 1ns / 1ps

module anp_front #(
	parameter int OFFSET_BITS = anp_pkg::OFFSET_BITS_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  logic [7:0]     stream_byte,
	input  logic           stream_end,
	input  logic           q_full,
	output logic           q_push,
	output anp_pkg::desc_t q_data
);
	import anp_pkg::*;

	typedef enum logic [1:0] {
		PH_SEARCH,
		PH_HEADER,
		PH_EXT,
		PH_PAYLOAD
	} phase_t;

	phase_t                 phase_q, phase_d;
	logic [23:0]            win_q, win_d;
	logic [1:0]             held_q, held_d;
	logic [OFFSET_BITS-1:0] cnt_q, cnt_d;
	logic [7:0]             hdr_q, hdr_d;
	logic [23:0]            ext_q, ext_d;
	logic [1:0]             extc_q, extc_d;
	logic [31:0]            uoff_q, uoff_d;

	logic                   accept;
	logic [23:0]            win_sh;
	logic [OFFSET_BITS+31:0] pos_wide;
	logic [23:0]            ext_out;
	logic                   has_hdr;
	logic                   has_end;
	logic [1:0]             pay_cnt;
	logic [2:0][7:0]        pay;

	function automatic logic is_svc(input logic [4:0] t);
		is_svc = (t == TYPE_SVC_PREFIX) || (t == TYPE_SVC_SLICE);
	endfunction

	assign accept   = push && !q_full;
	assign win_sh   = {win_q[15:0], stream_byte};
	assign pos_wide = {32'b0, cnt_q};

	always_comb begin
		phase_d = phase_q;
		win_d   = win_q;
		held_d  = held_q;
		cnt_d   = cnt_q;
		hdr_d   = hdr_q;
		ext_d   = ext_q;
		extc_d  = extc_q;
		uoff_d  = uoff_q;
		has_hdr = 1'b0;
		has_end = 1'b0;
		pay_cnt = 2'd0;
		pay     = '0;
		ext_out = '0;
		q_data  = '0;

		if (accept) begin
			cnt_d = cnt_q + {{(OFFSET_BITS-1){1'b0}}, 1'b1};
			case (phase_q)
				PH_SEARCH: begin
					win_d  = win_sh;
					held_d = (held_q == 2'd3) ? 2'd3 : held_q + 2'd1;
					if (held_d == 2'd3 && win_sh == WIN_START) begin
						phase_d = PH_HEADER;
						win_d   = '0;
						held_d  = 2'd0;
					end
				end
				PH_HEADER: begin
					hdr_d  = stream_byte;
					uoff_d = pos_wide[31:0];
					ext_d  = '0;
					extc_d = 2'd0;
					win_d  = '0;
					held_d = 2'd0;
					if (is_svc(stream_byte[4:0])) begin
						phase_d = PH_EXT;
					end else begin
						has_hdr = (stream_byte[4:0] != 5'd0);
						phase_d = PH_PAYLOAD;
					end
				end
				PH_EXT: begin
					ext_d  = {ext_q[15:0], stream_byte};
					extc_d = extc_q + 2'd1;
					if (extc_d == 2'd3) begin
						has_hdr = 1'b1;
						phase_d = PH_PAYLOAD;
					end
				end
				default: begin
					win_d  = win_sh;
					held_d = held_q + 2'd1;
					if (held_d == 2'd3) begin
						if (win_sh == WIN_ZERO || win_sh == WIN_START) begin
							// unit closes before a zero run or a new start code
							has_end = 1'b1;
							win_d   = '0;
							if (win_sh == WIN_START) begin
								phase_d = PH_HEADER;
								held_d  = 2'd0;
							end else begin
								phase_d = PH_SEARCH;
								held_d  = 2'd3;
							end
						end else if (win_sh == WIN_EPB) begin
							// drop the emulation-prevention byte
							pay_cnt = 2'd2;
							win_d   = '0;
							held_d  = 2'd0;
						end else begin
							pay_cnt = 2'd1;
							pay[0]  = win_sh[23:16];
							win_d   = {8'b0, win_sh[15:0]};
							held_d  = 2'd2;
						end
					end
				end
			endcase
		end

		ext_out = ext_d;
		if (accept && stream_end) begin
			if (phase_d == PH_EXT) begin
				// missing extension bytes read as zero in the low positions
				case (extc_d)
					2'd1:    ext_out = {ext_d[7:0], 16'b0};
					2'd2:    ext_out = {ext_d[15:0], 8'b0};
					default: ext_out = ext_d;
				endcase
				has_hdr = 1'b1;
				has_end = 1'b1;
			end else if (phase_d == PH_PAYLOAD) begin
				// flush held bytes, oldest first
				case (held_d)
					2'd1: begin
						pay[0]  = win_d[7:0];
						pay_cnt = 2'd1;
					end
					2'd2: begin
						if (pay_cnt == 2'd1) begin
							pay[1]  = win_d[15:8];
							pay[2]  = win_d[7:0];
							pay_cnt = 2'd3;
						end else begin
							pay[0]  = win_d[15:8];
							pay[1]  = win_d[7:0];
							pay_cnt = 2'd2;
						end
					end
					default: begin
					end
				endcase
				has_end = 1'b1;
			end
		end

		q_data.hdr_byte = hdr_d;
		q_data.ext      = is_svc(hdr_d[4:0]) ? ext_out : 24'b0;
		q_data.offset   = uoff_d;
		q_data.has_hdr  = has_hdr;
		q_data.pay_cnt  = pay_cnt;
		q_data.pay      = pay;
		q_data.has_end  = has_end;

		// stream end returns everything to the power-on state
		if (accept && stream_end) begin
			phase_d = PH_SEARCH;
			win_d   = '0;
			held_d  = 2'd0;
			cnt_d   = '0;
			hdr_d   = '0;
			ext_d   = '0;
			extc_d  = 2'd0;
			uoff_d  = '0;
		end
	end

	assign q_push = accept && (has_hdr || has_end || pay_cnt != 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SEARCH;
			win_q   <= '0;
			held_q  <= 2'd0;
			cnt_q   <= '0;
			hdr_q   <= '0;
			ext_q   <= '0;
			extc_q  <= 2'd0;
			uoff_q  <= '0;
		end else begin
			phase_q <= phase_d;
			win_q   <= win_d;
			held_q  <= held_d;
			cnt_q   <= cnt_d;
			hdr_q   <= hdr_d;
			ext_q   <= ext_d;
			extc_q  <= extc_d;
			uoff_q  <= uoff_d;
		end
	end

endmodule

// File: rtl/anp_back.sv
`timescale 1ns / 1ps

module anp_back (
	input  logic           clk,
	input  logic           arst_n,
	input  anp_pkg::desc_t q_data,
	input  logic           q_empty,
	output logic           q_pop,
	input  logic           pop,
	output logic           empty,
	output anp_pkg::res_t  res
);
	import anp_pkg::*;

	logic [1:0] idx_q;
	logic       valid_q;
	res_t       res_q;
	logic       load;
	logic [2:0] total;
	logic       is_last;
	kind_t      kind_c;
	logic [7:0] byte_c;
	logic [7:0] pay_at;

	assign total   = {2'b0, q_data.has_hdr} + {1'b0, q_data.pay_cnt}
	               + {2'b0, q_data.has_end};
	assign is_last = ({1'b0, idx_q} == total - 3'd1);
	assign load    = !q_empty && (!valid_q || pop);
	assign q_pop   = load && is_last;
	assign empty   = !valid_q;
	assign res     = res_q;

	always_comb begin
		case (idx_q)
			2'd0:    pay_at = q_data.pay[0];
			2'd1:    pay_at = q_data.pay[1];
			default: pay_at = q_data.pay[2];
		endcase
		byte_c = 8'd0;
		if (q_data.has_hdr) begin
			kind_c = (idx_q == 2'd0) ? KIND_HEADER : KIND_END;
		end else if (idx_q < q_data.pay_cnt) begin
			kind_c = KIND_PAYLOAD;
			byte_c = pay_at;
		end else begin
			kind_c = KIND_END;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q.kind          <= kind_c;
			res_q.nal_offset    <= q_data.offset;
			res_q.nal_type      <= q_data.hdr_byte[4:0];
			res_q.ref_idc       <= q_data.hdr_byte[6:5];
			res_q.forbidden_bit <= q_data.hdr_byte[7];
			res_q.hdr_ext       <= q_data.ext;
			res_q.payload_byte  <= byte_c;
			res_q.last          <= is_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= 2'd0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				idx_q   <= is_last ? 2'd0 : idx_q + 2'd1;
			end else if (pop) begin
				valid_q <= 1'b0;
			end
		end
	end

endmodule

// File: rtl/annexb_nal_unit_parser_top.sv
`timescale 1ns / 1ps

// channel   direction  handshake           beat carries
// input     in         push / full         stream_byte, stream_end
// results   out        empty / pop         kind, nal_offset, nal_type, ref_idc,
//                                          forbidden_bit, hdr_ext,
//                                          payload_byte, last
//
// one stream byte is taken per cycle while the descriptor queue has room
// results leave one per cycle from the output register while pop is held, up to four per byte,
// so a long run of multi-result bytes is paced by the result side
// first result of a byte passes through the descriptor queue, then the output register
// reset is asynchronous, active low, and needs no clearing pass
// a stalled result side fills the four-entry queue, then full rises

module annexb_nal_unit_parser_top #(
	parameter int OFFSET_BITS = anp_pkg::OFFSET_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  stream_byte,
	input  logic        stream_end,
	output logic        empty,
	input  logic        pop,
	output logic [1:0]  kind,
	output logic [31:0] nal_offset,
	output logic [4:0]  nal_type,
	output logic [1:0]  ref_idc,
	output logic        forbidden_bit,
	output logic [23:0] hdr_ext,
	output logic [7:0]  payload_byte,
	output logic        last
);
	import anp_pkg::*;

	// front to queue
	logic  q_push;
	desc_t q_wdata;
	logic  q_full;
	// queue to back
	desc_t q_rdata;
	logic  q_empty;
	logic  q_pop;
	res_t  res;

	// byte scanner: start codes, header capture, emulation-prevention removal
	anp_front #(
		.OFFSET_BITS (OFFSET_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.stream_byte (stream_byte),
		.stream_end  (stream_end),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_data      (q_wdata)
	);

	// one descriptor per byte that causes any result
	anp_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (q_push),
		.wr_data (q_wdata),
		.full    (q_full),
		.rd_en   (q_pop),
		.rd_data (q_rdata),
		.empty   (q_empty)
	);

	// expands a descriptor into its result beats
	anp_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_data  (q_rdata),
		.q_empty (q_empty),
		.q_pop   (q_pop),
		.pop     (pop),
		.empty   (empty),
		.res     (res)
	);

	assign full          = q_full;
	assign kind          = res.kind;
	assign nal_offset    = res.nal_offset;
	assign nal_type      = res.nal_type;
	assign ref_idc       = res.ref_idc;
	assign forbidden_bit = res.forbidden_bit;
	assign hdr_ext       = res.hdr_ext;
	assign payload_byte  = res.payload_byte;
	assign last          = res.last;

endmodule

// File: verif/tb_annexb_nal_unit_parser_top.sv
`timescale 1ns / 1ps

module tb_annexb_nal_unit_parser_top;

	import anp_pkg::*;

	// where the splitter is in the byte stream
	typedef enum logic [1:0] {
		LOOK_FOR_START,
		TAKE_HEADER,
		TAKE_EXT,
		IN_PAYLOAD
	} scan_phase_t;

	// one byte waiting to go into the block; drain holds it back until
	// every result predicted so far has come out
	typedef struct {
		logic [7:0] data;
		logic       fin;
		bit         drain;
	} stream_item_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	logic [7:0]  stream_byte = 8'h00;
	logic        stream_end = 1'b0;
	logic        empty;
	logic        pop = 1'b0;
	logic [1:0]  kind;
	logic [31:0] nal_offset;
	logic [4:0]  nal_type;
	logic [1:0]  ref_idc;
	logic        forbidden_bit;
	logic [23:0] hdr_ext;
	logic [7:0]  payload_byte;
	logic        last;

	annexb_nal_unit_parser_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.stream_byte   (stream_byte),
		.stream_end    (stream_end),
		.empty         (empty),
		.pop           (pop),
		.kind          (kind),
		.nal_offset    (nal_offset),
		.nal_type      (nal_type),
		.ref_idc       (ref_idc),
		.forbidden_bit (forbidden_bit),
		.hdr_ext       (hdr_ext),
		.payload_byte  (payload_byte),
		.last          (last)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// hard stop in case the block hangs
	initial begin
		#5_000_000;
		$display("** annexb_nal_unit_parser_top: FAILED **");
		$finish;
	end

	// ------------------------------------------------------------------
	// splitter state as the testbench sees it
	// ------------------------------------------------------------------
	scan_phase_t phase = LOOK_FOR_START;
	logic [23:0] window = 24'h0;      // last bytes held for start code / epb checks
	int          held = 0;            // how many of them are valid
	logic [31:0] byte_pos = 32'h0;    // offset of the next stream byte
	logic [7:0]  hdr = 8'h00;         // header byte of the unit in progress
	logic [23:0] ext = 24'h0;         // svc extension bytes collected so far
	int          ext_cnt = 0;
	logic [31:0] unit_off = 32'h0;

	res_t        burst[5];            // results of the byte being parsed
	int          burst_n;
	res_t        pending_results[$];  // predicted results not yet popped

	stream_item_t stream_feed[$];
	stream_item_t next_item;
	int          feed_total = 0;
	bit          drain_next = 1'b0;

	int          bytes_sent = 0;
	int          bytes_taken = 0;
	int          bad_count = 0;
	int          tx_gap = 0;
	int          rx_wait = 0;
	bit          quiet_tx = 1'b0;
	bit          quiet_rx = 1'b0;
	res_t        got;
	res_t        want;

	function automatic bit is_svc(logic [4:0] t);
		return t == TYPE_SVC_PREFIX || t == TYPE_SVC_SLICE;
	endfunction

	// every result carries the header fields of the current unit
	function automatic void add_result(kind_t k, logic [7:0] pb);
		if (burst_n < 5) begin
			burst[burst_n] = '{
				kind:          k,
				nal_offset:    unit_off,
				nal_type:      hdr[4:0],
				ref_idc:       hdr[6:5],
				forbidden_bit: hdr[7],
				hdr_ext:       is_svc(hdr[4:0]) ? ext : 24'h0,
				payload_byte:  pb,
				last:          1'b0
			};
			burst_n++;
		end
	endfunction

	// advance the splitter by one accepted byte and queue what it emits
	task automatic parse_byte(input logic [7:0] b, input logic fin);
		logic [23:0] w;
		logic [31:0] here;
		res_t        r;
		int          i;
		burst_n = 0;
		here = byte_pos;
		byte_pos = byte_pos + 32'd1;
		case (phase)
			LOOK_FOR_START: begin
				// zeros pile up, anything else that is not a closing 01 falls out
				window = {window[15:0], b};
				if (held < 3)
					held++;
				if (held == 3 && window == WIN_START) begin
					phase = TAKE_HEADER;
					window = 24'h0;
					held = 0;
				end
			end
			TAKE_HEADER: begin
				hdr = b;
				unit_off = here;
				ext = 24'h0;
				ext_cnt = 0;
				window = 24'h0;
				held = 0;
				if (is_svc(b[4:0])) begin
					phase = TAKE_EXT;
				end else begin
					// type zero units get no header record
					if (b[4:0] != 5'd0)
						add_result(KIND_HEADER, 8'h00);
					phase = IN_PAYLOAD;
				end
			end
			TAKE_EXT: begin
				ext = {ext[15:0], b};
				ext_cnt++;
				if (ext_cnt == 3) begin
					add_result(KIND_HEADER, 8'h00);
					phase = IN_PAYLOAD;
				end
			end
			default: begin
				window = {window[15:0], b};
				held++;
				if (held == 3) begin
					w = window;
					if (w == WIN_ZERO || w == WIN_START) begin
						// unit closes; 00 00 00 keeps counting toward the next start
						add_result(KIND_END, 8'h00);
						window = 24'h0;
						if (w == WIN_START) begin
							phase = TAKE_HEADER;
							held = 0;
						end else begin
							phase = LOOK_FOR_START;
							held = 3;
						end
					end else if (w == WIN_EPB) begin
						// emulation prevention: pass the two zeros, drop the 03
						add_result(KIND_PAYLOAD, 8'h00);
						add_result(KIND_PAYLOAD, 8'h00);
						window = 24'h0;
						held = 0;
					end else begin
						add_result(KIND_PAYLOAD, w[23:16]);
						window = {8'h00, w[15:0]};
						held = 2;
					end
				end
			end
		endcase
		if (fin) begin
			if (phase == TAKE_EXT) begin
				// short extension is padded with zeros below what arrived
				while (ext_cnt < 3) begin
					ext = {ext[15:0], 8'h00};
					ext_cnt++;
				end
				add_result(KIND_HEADER, 8'h00);
				add_result(KIND_END, 8'h00);
			end else if (phase == IN_PAYLOAD) begin
				for (i = held; i > 0; i--)
					add_result(KIND_PAYLOAD, window[8 * i - 1 -: 8]);
				add_result(KIND_END, 8'h00);
			end
			// new stream starts from scratch, offsets included
			phase = LOOK_FOR_START;
			window = 24'h0;
			held = 0;
			byte_pos = 32'h0;
			hdr = 8'h00;
			ext = 24'h0;
			ext_cnt = 0;
			unit_off = 32'h0;
		end
		for (i = 0; i < burst_n; i++) begin
			r = burst[i];
			r.last = (i == burst_n - 1);
			pending_results.push_back(r);
		end
	endtask

	// ------------------------------------------------------------------
	// stimulus building
	// ------------------------------------------------------------------
	task automatic put_stream(input logic [7:0] bs[$], input bit finish);
		stream_item_t it;
		int i;
		for (i = 0; i < bs.size(); i++) begin
			it.data = bs[i];
			it.fin = finish && (i == bs.size() - 1);
			it.drain = drain_next;
			drain_next = 1'b0;
			stream_feed.push_back(it);
			feed_total++;
		end
	endtask

	// payload content leaning on the bytes that matter to the scanner
	function automatic logic [7:0] body_byte();
		int r;
		r = $urandom_range(0, 99);
		if (r < 25)
			return 8'h00;
		if (r < 33)
			return 8'h03;
		if (r < 37)
			return 8'h01;
		return 8'($urandom_range(0, 255));
	endfunction

	function automatic logic [7:0] header_byte();
		int r;
		logic [4:0] t;
		r = $urandom_range(0, 99);
		if (r < 30)
			t = $urandom_range(0, 1) ? TYPE_SVC_PREFIX : TYPE_SVC_SLICE;
		else if (r < 40)
			t = 5'd0;
		else
			t = 5'($urandom_range(1, 31));
		return {($urandom_range(0, 9) == 0), 2'($urandom_range(0, 3)), t};
	endfunction

	// one stream: optional junk, a few units, then one of several ways to stop
	task automatic random_stream();
		logic [7:0] bs[$];
		logic [7:0] hb;
		int units, mode, n_ext, len, u;
		if ($urandom_range(0, 9) == 0) begin
			// plain noise
			repeat ($urandom_range(4, 12)) bs.push_back(body_byte());
			put_stream(bs, 1'($urandom_range(0, 1)));
			return;
		end
		repeat ($urandom_range(0, 2)) bs.push_back(8'($urandom_range(1, 255)));
		units = $urandom_range(1, 3);
		// 0 end in payload, 1 end inside extension, 2 end while searching, 3 no end
		mode = $urandom_range(0, 3);
		for (u = 0; u < units; u++) begin
			// two zeros give the short start code, three or four the long one
			repeat ($urandom_range(2, 4)) bs.push_back(8'h00);
			bs.push_back(8'h01);
			hb = header_byte();
			bs.push_back(hb);
			if (is_svc(hb[4:0])) begin
				n_ext = (u == units - 1 && mode == 1) ? $urandom_range(0, 2) : 3;
				repeat (n_ext) bs.push_back(8'($urandom_range(0, 255)));
				if (n_ext < 3)
					break;
			end
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 8);
			repeat (len) bs.push_back(body_byte());
		end
		if (mode == 2)
			repeat (3) bs.push_back(8'h00);
		put_stream(bs, mode != 3);
	endtask

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// now and then switch a side into a stretch with no idling
	always @(posedge clk) begin
		if ($urandom_range(0, 199) == 0)
			quiet_tx = ($urandom_range(0, 2) == 0);
		if ($urandom_range(0, 199) == 0)
			quiet_rx = ($urandom_range(0, 2) == 0);
	end

	// ------------------------------------------------------------------
	// driver: one beat at a time, next one only after the last was taken
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (arst_n && !(push && bytes_taken != bytes_sent)) begin
			if (tx_gap > 0) begin
				tx_gap--;
				push <= 1'b0;
			end else if (stream_feed.size() == 0 ||
					(stream_feed[0].drain && pending_results.size() != 0)) begin
				push <= 1'b0;
			end else begin
				next_item = stream_feed.pop_front();
				stream_byte <= next_item.data;
				stream_end <= next_item.fin;
				push <= 1'b1;
				bytes_sent++;
				tx_gap = quiet_tx ? 0 : idle_len();
			end
		end
	end

	// result side stalls
	always @(negedge clk) begin
		if (arst_n) begin
			if (rx_wait > 0) begin
				rx_wait--;
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
				rx_wait = quiet_rx ? 0 : idle_len();
			end
		end
	end

	// ------------------------------------------------------------------
	// monitor: predict on accepted input beats, check popped results
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (push && !full) begin
				parse_byte(stream_byte, stream_end);
				bytes_taken++;
			end
			if (pop && !empty) begin
				got = {kind, nal_offset, nal_type, ref_idc, forbidden_bit,
					hdr_ext, payload_byte, last};
				if (pending_results.size() == 0) begin
					bad_count++;
					if (bad_count <= 10)
						$display("%0t: result with nothing expected: kind %0d off %h",
							$realtime, got.kind, got.nal_offset);
				end else begin
					want = pending_results.pop_front();
					if (got !== want) begin
						bad_count++;
						if (bad_count <= 10)
							$display({"%0t: mismatch exp/act kind %0d/%0d off %h/%h",
								" type %0d/%0d ref %0d/%0d fb %0b/%0b ext %h/%h",
								" byte %h/%h last %0b/%0b"}, $realtime,
								want.kind, got.kind, want.nal_offset, got.nal_offset,
								want.nal_type, got.nal_type, want.ref_idc, got.ref_idc,
								want.forbidden_bit, got.forbidden_bit,
								want.hdr_ext, got.hdr_ext,
								want.payload_byte, got.payload_byte,
								want.last, got.last);
					end
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// stimulus, reset and end of run
	// ------------------------------------------------------------------
	initial begin
		logic [7:0] bs[$];
		int n_streams;
		// junk before the first start code, emulation prevention, unit closed
		// by zeros that then finish a start code, type zero unit, forbidden bit,
		// full svc extension, stream ending inside an svc extension
		bs = '{8'hFF, 8'h00, 8'h00, 8'h01, 8'hE5, 8'h00, 8'h00, 8'h03, 8'h00,
			8'h00, 8'h00, 8'h01, 8'h60, 8'h7F, 8'h00, 8'h00, 8'h01, 8'h2E,
			8'h12, 8'h34, 8'h56, 8'h00, 8'h00, 8'h01, 8'h14, 8'hAB};
		put_stream(bs, 1'b1);
		// stream ending in payload with bytes still held
		bs = '{8'h00, 8'h00, 8'h01, 8'h1F, 8'hFE, 8'h00};
		put_stream(bs, 1'b1);

		n_streams = 0;
		while (feed_total < 240) begin
			if (n_streams % 5 == 0)
				drain_next = 1'b1;
			random_stream();
			n_streams++;
		end

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		wait (bytes_taken == feed_total);
		while (pending_results.size() != 0)
			@(posedge clk);
		// catch anything extra the block might still push out
		repeat (20) @(posedge clk);

		if (bad_count == 0)
			$display("** annexb_nal_unit_parser_top: PASSED **");
		else
			$display("** annexb_nal_unit_parser_top: FAILED **");
		$finish;
	end

endmodule
